// File: rtl/rlae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlae_pkg;

    // Opcodes of an input transaction
    localparam logic [1:0] OP_WR_C1 = 2'd0;
    localparam logic [1:0] OP_WR_C2 = 2'd1;
    localparam logic [1:0] OP_MODE  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // LED modes
    localparam logic [2:0] MODE_OFF        = 3'd0;
    localparam logic [2:0] MODE_ON1        = 3'd1;
    localparam logic [2:0] MODE_ON2        = 3'd2;
    localparam logic [2:0] MODE_FLASH_SLOW = 3'd3;
    localparam logic [2:0] MODE_FLASH_FAST = 3'd4;
    localparam logic [2:0] MODE_PULSE_SLOW = 3'd5;
    localparam logic [2:0] MODE_PULSE_FAST = 3'd6;

    // Animation timing, in milliseconds
    localparam int SLOW_PERIOD = 2000;
    localparam int SLOW_HALF   = 1000;
    localparam int SLOW_RAMP   = 1000;
    localparam int SLOW_DIV    = 999;
    localparam int FAST_PERIOD = 200;
    localparam int FAST_HALF   = 100;
    localparam int FAST_DIV    = 199;

    // Reciprocals for division by a constant: floor(x / d) = (x * R) >> s,
    // exact over the whole range of x
    localparam logic [28:0] RECIP_125 = 29'd274877907; // d = 125, 28-bit x, s = 35
    localparam logic [8:0]  RECIP_25  = 9'd328;        // d = 25, 8-bit x, s = 13
    localparam logic [26:0] RECIP_999 = 27'd68788266;  // d = 999, x = m << 16, s = 36
    localparam logic [24:0] RECIP_199 = 25'd21582751;  // d = 199, x = m << 16, s = 32

    // 1.0 in the Q1.16 blend fraction (17 bits wide)
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Reset value of the active LED count
    localparam logic [5:0] ACTIVE_RESET = 6'd32;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  led_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [2:0]  mode_in;
        logic [31:0] time_ms;
    } t_item;

    typedef struct packed {
        logic [4:0]  led_number;
        logic [23:0] grb_word;
        logic        last_led;
    } t_result;

    // Classified command passed from the front end to the LED engine
    typedef struct packed {
        logic        is_tick;
        logic [1:0]  opcode;
        logic [4:0]  led_index;
        logic [23:0] word;
        logic [2:0]  mode;
        logic        slow;
        logic        fast;
        logic [16:0] frac_slow;
        logic [16:0] frac_fast;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/rlae_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rlae_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire rlae_pkg::t_item i_item,
    input  wire logic            i_full,
    output logic                 o_push,
    output rlae_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUO,
        S_REM,
        S_SPLIT,
        S_FRAC,
        S_PUSH
    } t_fstate;

    t_fstate      r_state;
    logic [31:0]  r_time;
    logic [21:0]  r_q;
    logic [10:0]  r_ms;
    logic [9:0]   r_rs;
    logic [7:0]   r_rf;
    logic [16:0]  r_qs;
    logic [16:0]  r_qf;
    logic         r_slow;
    logic         r_fast;

    logic         accept;
    logic [3:0]   q_fast;
    logic [7:0]   mf_nx;
    logic [9:0]   m_slow;

    assign busy   = (r_state != S_IDLE) || i_full;
    assign accept = start && !busy;

    // Split the mod-2000 remainder into its mod-1000 and mod-200 parts
    always_comb begin
        q_fast = 4'((17'(r_ms[10:3]) * 17'(rlae_pkg::RECIP_25)) >> 13);
        mf_nx  = 8'(r_ms - 11'(q_fast) * 11'(rlae_pkg::FAST_PERIOD));
        m_slow = (r_ms >= 11'(rlae_pkg::SLOW_RAMP)) ?
                 10'(r_ms - 11'(rlae_pkg::SLOW_RAMP)) : r_ms[9:0];
    end

    // Command toward the queue: a write passes straight through, a tick after its math
    always_comb begin
        o_cmd           = '0;
        o_push          = 1'b0;
        if (r_state == S_PUSH) begin
            o_push          = !i_full;
            o_cmd.is_tick   = 1'b1;
            o_cmd.opcode    = rlae_pkg::OP_TICK;
            o_cmd.slow      = r_slow;
            o_cmd.fast      = r_fast;
            o_cmd.frac_slow = r_slow ? 17'(rlae_pkg::ONE_Q16 - r_qs) : r_qs;
            o_cmd.frac_fast = r_fast ? 17'(rlae_pkg::ONE_Q16 - r_qf) : r_qf;
        end else begin
            o_push          = accept && (i_item.opcode != rlae_pkg::OP_TICK);
            o_cmd.opcode    = i_item.opcode;
            o_cmd.led_index = i_item.led_index;
            o_cmd.word      = {i_item.green_in, i_item.red_in, i_item.blue_in};
            o_cmd.mode      = i_item.mode_in;
        end
    end

    // Sequencer for tick timing: quotient, remainder, split, fractions, push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_item.opcode == rlae_pkg::OP_TICK)) begin
                        r_time  <= i_item.time_ms;
                        r_state <= S_QUO;
                    end
                end
                S_QUO: begin
                    // time / 2000 as (time >> 4) / 125
                    r_q     <= 22'((57'(r_time[31:4]) * 57'(rlae_pkg::RECIP_125)) >> 35);
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_ms    <= 11'(r_time - 32'(r_q) * 32'(rlae_pkg::SLOW_PERIOD));
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_rs    <= m_slow;
                    r_rf    <= mf_nx;
                    r_slow  <= (r_ms > 11'(rlae_pkg::SLOW_HALF));
                    r_state <= S_FRAC;
                end
                S_FRAC: begin
                    // m * 2^16 / divisor, truncated
                    r_qs    <= 17'((37'(r_rs) * 37'(rlae_pkg::RECIP_999)) >> 20);
                    r_qf    <= 17'((33'(r_rf) * 33'(rlae_pkg::RECIP_199)) >> 16);
                    r_fast  <= (r_rf > 8'(rlae_pkg::FAST_HALF));
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/rlae_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rlae_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rlae_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output rlae_pkg::t_cmd       o_cmd,
    output logic                 o_full,
    output logic                 o_empty
);

    // Two-entry command queue
    rlae_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= 2'(r_cnt + {1'b0, do_push} - {1'b0, do_pop});
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rlae_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rlae_back #(
    parameter int MAX_LEDS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [5:0]       i_active,
    input  wire rlae_pkg::t_cmd   i_cmd,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    output rlae_pkg::t_result     o_result
);

    localparam int DEPTH = (MAX_LEDS < 32) ? MAX_LEDS : 32;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        B_IDLE,
        B_WALK
    } t_bstate;

    // One color channel: a + (b - a) * f / 2^16, rounded toward minus infinity
    function automatic logic [7:0] f_mix(input logic [7:0] a, input logic [7:0] b,
                                         input logic [16:0] f);
        logic signed [8:0]  d;
        logic signed [17:0] fq;
        logic signed [26:0] p;
        logic [10:0]        s;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        fq   = $signed({1'b0, f});
        p    = d * fq;
        s    = {3'b000, a} + p[26:16];
        return s[7:0];
    endfunction

    function automatic logic [23:0] f_blend(input logic [23:0] c1, input logic [23:0] c2,
                                            input logic [16:0] f);
        return {f_mix(c1[23:16], c2[23:16], f),
                f_mix(c1[15:8], c2[15:8], f),
                f_mix(c1[7:0], c2[7:0], f)};
    endfunction

    // LED table
    logic [23:0]   r_c1    [DEPTH];
    logic [23:0]   r_c2    [DEPTH];
    logic [2:0]    r_mode  [DEPTH];
    logic [23:0]   r_shown [DEPTH];

    t_bstate       r_state;
    logic [IW-1:0] r_i;
    logic          r_slow;
    logic          r_fast;
    logic [16:0]   r_fs;
    logic [16:0]   r_ff;

    // Fetch stage
    logic          r_s1_valid;
    logic [IW-1:0] r_s1_idx;
    logic [2:0]    r_s1_mode;
    logic [23:0]   r_s1_c1;
    logic [23:0]   r_s1_c2;
    logic [23:0]   r_s1_shown;
    logic          r_s1_last;

    // Result stage
    logic                r_valid;
    rlae_pkg::t_result   r_result;

    logic [5:0]    count;
    logic          wr_hit;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] rd_idx;
    logic [23:0]   rd_c1;
    logic [23:0]   rd_c2;
    logic [2:0]    rd_mode;
    logic [23:0]   rd_shown;
    logic [23:0]   new_word;
    logic          upd;
    logic          walk_last;

    assign count = (i_active > 6'(DEPTH)) ? 6'(DEPTH) : i_active;

    assign o_pop   = (r_state == B_IDLE) && !i_empty && !r_s1_valid;
    assign wr_hit  = o_pop && !i_cmd.is_tick && ({1'b0, i_cmd.led_index} < count);
    assign wr_idx  = i_cmd.led_index[IW-1:0];

    // Single table read port: walker address while walking, write target otherwise
    assign rd_idx   = (r_state == B_WALK) ? r_i : wr_idx;
    assign rd_c1    = r_c1[rd_idx];
    assign rd_c2    = r_c2[rd_idx];
    assign rd_mode  = r_mode[rd_idx];
    assign rd_shown = r_shown[rd_idx];

    assign walk_last = (6'(r_i) == 6'(count - 6'd1));

    // Animation step for the fetched LED
    always_comb begin
        upd      = 1'b0;
        new_word = r_s1_shown;
        case (r_s1_mode)
            rlae_pkg::MODE_FLASH_SLOW: begin
                upd      = 1'b1;
                new_word = r_slow ? r_s1_c1 : r_s1_c2;
            end
            rlae_pkg::MODE_FLASH_FAST: begin
                upd      = 1'b1;
                new_word = r_fast ? r_s1_c1 : r_s1_c2;
            end
            rlae_pkg::MODE_PULSE_SLOW: begin
                upd      = 1'b1;
                new_word = f_blend(r_s1_c1, r_s1_c2, r_fs);
            end
            rlae_pkg::MODE_PULSE_FAST: begin
                upd      = 1'b1;
                new_word = f_blend(r_s1_c1, r_s1_c2, r_ff);
            end
            default: begin
                upd      = 1'b0;
                new_word = r_s1_shown;
            end
        endcase
    end

    // Table updates from write commands and from the tick walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_c1[k]    <= '0;
                r_c2[k]    <= '0;
                r_mode[k]  <= rlae_pkg::MODE_OFF;
                r_shown[k] <= '0;
            end
        end else begin
            if (r_s1_valid && upd) begin
                r_shown[r_s1_idx] <= new_word;
            end
            if (wr_hit) begin
                unique case (i_cmd.opcode)
                    rlae_pkg::OP_WR_C1: begin
                        r_c1[wr_idx] <= i_cmd.word;
                    end
                    rlae_pkg::OP_WR_C2: begin
                        r_c2[wr_idx] <= i_cmd.word;
                    end
                    rlae_pkg::OP_MODE: begin
                        r_mode[wr_idx] <= i_cmd.mode;
                        case (i_cmd.mode)
                            rlae_pkg::MODE_OFF: r_shown[wr_idx] <= '0;
                            rlae_pkg::MODE_ON1: r_shown[wr_idx] <= rd_c1;
                            rlae_pkg::MODE_ON2: r_shown[wr_idx] <= rd_c2;
                            default:            r_shown[wr_idx] <= rd_shown;
                        endcase
                    end
                    default: begin
                        r_mode[wr_idx] <= rd_mode;
                    end
                endcase
            end
        end
    end

    // Walker state machine, fetch stage and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_i        <= '0;
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s1_valid <= 1'b0;
            r_valid    <= r_s1_valid;
            r_result   <= '{led_number: 5'(r_s1_idx), grb_word: new_word,
                            last_led: r_s1_last};
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop && i_cmd.is_tick && (count != 6'd0)) begin
                        r_slow  <= i_cmd.slow;
                        r_fast  <= i_cmd.fast;
                        r_fs    <= i_cmd.frac_slow;
                        r_ff    <= i_cmd.frac_fast;
                        r_i     <= '0;
                        r_state <= B_WALK;
                    end
                end
                B_WALK: begin
                    r_s1_valid <= 1'b1;
                    r_s1_idx   <= r_i;
                    r_s1_mode  <= rd_mode;
                    r_s1_c1    <= rd_c1;
                    r_s1_c2    <= rd_c2;
                    r_s1_shown <= rd_shown;
                    r_s1_last  <= walk_last;
                    r_i        <= IW'(r_i + 1'b1);
                    if (walk_last) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: rtl/rgb_led_animation_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB LED animation engine. A transaction is taken when start is high and busy
// is low. Color and mode writes go through the queue to the LED engine. A tick
// passes through the front end (reciprocal multiplies give the time
// remainders, then the pulse fractions) before it is queued, and busy stays high
// meanwhile; the engine then walks the n active LEDs at one per cycle.
// Results appear on o_result, one per cycle with o_valid high, in LED order,
// the last one flagged; the receiver has no way to stall them and must take
// each on the cycle it is shown. A two-entry command queue lets the front end
// take further transactions while the engine is still emitting.
module rgb_led_animation_engine_unit #(
    parameter int MAX_LEDS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rlae_pkg::t_item   i_item,
    output logic                   o_valid,
    output rlae_pkg::t_result      o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [5:0]        i_cfg_data
);

    logic [5:0]     r_active;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    rlae_pkg::t_cmd front_cmd;
    rlae_pkg::t_cmd back_cmd;

    // Active LED count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= rlae_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_data;
        end
    end

    rlae_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    rlae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    rlae_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (r_active),
        .i_cmd    (back_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: bench/led_frame_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the LED animation engine,
// keeps its own copy of the LED table and checks every emitted GRB word.
module led_frame_checker
    import rlae_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_busy,
    input  wire t_item      i_item,
    input  wire logic       i_valid,
    input  wire t_result    i_result,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_data,
    output int              o_errors,
    output int              o_pending
);

    localparam int LED_SLOTS = 32;

    // Shadow LED table
    logic [23:0] colour_one [LED_SLOTS];
    logic [23:0] colour_two [LED_SLOTS];
    logic [2:0]  mode_of    [LED_SLOTS];
    logic [23:0] shown      [LED_SLOTS];
    logic [5:0]  active_cfg;

    // GRB words still owed by the engine, oldest first
    t_result frames_due[$];

    initial o_errors = 0;
    initial o_pending = 0;

    function automatic int driven_leds();
        return (active_cfg > 6'd32) ? 32 : int'(active_cfg);
    endfunction

    // Per-channel c1 + (c2 - c1) * f, f in Q1.16 with 1.0 exact, truncated
    function automatic logic [23:0] blend_pair(input logic [23:0] c1, input logic [23:0] c2,
                                               input logic [31:0] frac);
        logic [23:0] mix;
        logic [31:0] a, b, v;
        mix = '0;
        for (int k = 0; k < 3; k++) begin
            a = 32'(c1[8*k +: 8]);
            b = 32'(c2[8*k +: 8]);
            v = (a * (32'(ONE_Q16) - frac) + b * frac) >> 16;
            mix[8*k +: 8] = v[7:0];
        end
        return mix;
    endfunction

    // Animate flash/pulse LEDs for this time, then queue one word per LED
    task automatic animate_and_emit(input logic [31:0] now);
        logic [31:0] m_slow, m_fast, f_slow, f_fast;
        logic        in_slow, in_fast;
        int          n;
        t_result     r;
        n = driven_leds();
        m_slow = now % 32'(SLOW_PERIOD);
        m_fast = now % 32'(FAST_PERIOD);
        in_slow = m_slow > 32'(SLOW_HALF);
        in_fast = m_fast > 32'(FAST_HALF);
        f_slow = ((now % 32'(SLOW_RAMP)) << 16) / 32'(SLOW_DIV);
        f_fast = (m_fast << 16) / 32'(FAST_DIV);
        if (in_slow) f_slow = 32'(ONE_Q16) - f_slow;
        if (in_fast) f_fast = 32'(ONE_Q16) - f_fast;
        for (int i = 0; i < n; i++) begin
            case (mode_of[i])
                MODE_FLASH_SLOW: shown[i] = in_slow ? colour_one[i] : colour_two[i];
                MODE_FLASH_FAST: shown[i] = in_fast ? colour_one[i] : colour_two[i];
                MODE_PULSE_SLOW: shown[i] = blend_pair(colour_one[i], colour_two[i], f_slow);
                MODE_PULSE_FAST: shown[i] = blend_pair(colour_one[i], colour_two[i], f_fast);
                default: ;
            endcase
        end
        for (int i = 0; i < n; i++) begin
            r.led_number = 5'(i);
            r.grb_word = shown[i];
            r.last_led = (i == n - 1);
            frames_due.push_back(r);
        end
    endtask

    // Table writes; anything at or past the driven count is dropped
    task automatic apply_write(input t_item it);
        logic [23:0] grb;
        int          idx;
        grb = {it.green_in, it.red_in, it.blue_in};
        idx = int'(it.led_index);
        if (idx < driven_leds()) begin
            case (it.opcode)
                OP_WR_C1: colour_one[idx] = grb;
                OP_WR_C2: colour_two[idx] = grb;
                default: begin
                    mode_of[idx] = it.mode_in;
                    case (it.mode_in)
                        MODE_OFF: shown[idx] = '0;
                        MODE_ON1: shown[idx] = colour_one[idx];
                        MODE_ON2: shown[idx] = colour_two[idx];
                        default: ;
                    endcase
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < LED_SLOTS; i++) begin
                colour_one[i] = '0;
                colour_two[i] = '0;
                mode_of[i] = MODE_OFF;
                shown[i] = '0;
            end
            active_cfg = ACTIVE_RESET;
            frames_due.delete();
        end else begin
            // Compare the result transaction against the oldest owed word
            if (i_valid) begin
                if (frames_due.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display("%0t: unexpected result, expected none, actual led %0d grb %06h last %0b",
                             $time, i_result.led_number, i_result.grb_word, i_result.last_led);
                end else begin
                    want = frames_due.pop_front();
                    if (i_result.led_number !== want.led_number) begin
                        o_errors = o_errors + 1;
                        $display("%0t: led_number expected %0d actual %0d",
                                 $time, want.led_number, i_result.led_number);
                    end
                    if (i_result.grb_word !== want.grb_word) begin
                        o_errors = o_errors + 1;
                        $display("%0t: grb_word (led %0d) expected %06h actual %06h",
                                 $time, want.led_number, want.grb_word, i_result.grb_word);
                    end
                    if (i_result.last_led !== want.last_led) begin
                        o_errors = o_errors + 1;
                        $display("%0t: last_led (led %0d) expected %0b actual %0b",
                                 $time, want.led_number, want.last_led, i_result.last_led);
                    end
                end
            end
            if (i_cfg_we) active_cfg = i_cfg_data;
            // Command transaction taken at this edge
            if (i_start && !i_busy) begin
                if (i_item.opcode == OP_TICK) animate_and_emit(i_item.time_ms);
                else apply_write(i_item);
            end
        end
        o_pending = frames_due.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import rlae_pkg::*;

    localparam logic [2:0] MODE_UNDEF = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 200;
    localparam int SEGMENTS = 6;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_item      i_item;
    logic       o_valid;
    t_result    o_result;
    logic       i_cfg_we;
    logic [5:0] i_cfg_data;

    int errors;
    int pending;
    int cycles = 0;
    int idle_pct;
    int led_count;

    rgb_led_animation_engine_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    led_frame_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (i_item),
        .i_valid    (o_valid),
        .i_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_item make_item(input logic [1:0] op, input logic [4:0] idx,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [2:0] mode,
                                        input logic [31:0] now);
        t_item it;
        it.opcode = op;
        it.led_index = idx;
        it.red_in = r;
        it.green_in = g;
        it.blue_in = b;
        it.mode_in = mode;
        it.time_ms = now;
        return it;
    endfunction

    // Random command; times cluster around the flash and pulse phase edges half the time
    function automatic t_item random_item(input int n);
        t_item       it;
        int          pick;
        logic [31:0] offs;
        it.red_in = 8'($urandom);
        it.green_in = 8'($urandom);
        it.blue_in = 8'($urandom);
        it.mode_in = 3'($urandom_range(7));
        pick = int'($urandom_range(99));
        if (pick < 20) it.opcode = OP_WR_C1;
        else if (pick < 40) it.opcode = OP_WR_C2;
        else if (pick < 65) it.opcode = OP_MODE;
        else it.opcode = OP_TICK;
        if (n > 0 && $urandom_range(99) < 85) it.led_index = 5'($urandom_range(n - 1));
        else it.led_index = 5'($urandom_range(31));
        case ($urandom_range(12))
            0: offs = 32'd0;
            1: offs = 32'd99;
            2: offs = 32'd100;
            3: offs = 32'd101;
            4: offs = 32'd199;
            5: offs = 32'd200;
            6: offs = 32'd999;
            7: offs = 32'd1000;
            8: offs = 32'd1001;
            9: offs = 32'd1099;
            10: offs = 32'd1101;
            11: offs = 32'd1999;
            default: offs = 32'($urandom_range(1999));
        endcase
        if ($urandom_range(1) == 1) it.time_ms = $urandom;
        else it.time_ms = 32'($urandom_range(2147482)) * 32'd2000 + offs;
        return it;
    endfunction

    // Present one transaction from a falling edge, hold until taken
    task automatic send(input t_item it);
        while (int'($urandom_range(99)) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain all owed words, then let queued commands finish
    task automatic settle();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_count(input logic [5:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        led_count = (v > 6'd32) ? 32 : int'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int    seg;
        int    useful;
        int    target;
        t_item it;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        idle_pct = 14;
        led_count = 32;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: all-off frame, snapshots, every animation mode, phase edges
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C1, 5'd0, 8'hff, 8'hff, 8'hff, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C2, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C1, 5'd3, 8'h12, 8'h34, 8'h56, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C2, 5'd1, 8'hff, 8'hff, 8'hff, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C1, 5'd31, 8'ha5, 8'h5a, 8'h3c, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C2, 5'd31, 8'h0f, 8'hf0, 8'h81, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C1, 5'd2, 8'h80, 8'h01, 8'h7f, MODE_OFF, 32'd0));
        send(make_item(OP_MODE, 5'd0, 8'h00, 8'h00, 8'h00, MODE_ON1, 32'd0));
        send(make_item(OP_MODE, 5'd1, 8'h00, 8'h00, 8'h00, MODE_ON2, 32'd0));
        send(make_item(OP_MODE, 5'd3, 8'h00, 8'h00, 8'h00, MODE_ON1, 32'd0));
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd1000));
        // undefined mode keeps the word it had
        send(make_item(OP_MODE, 5'd3, 8'h00, 8'h00, 8'h00, MODE_UNDEF, 32'd0));
        send(make_item(OP_MODE, 5'd0, 8'h00, 8'h00, 8'h00, MODE_PULSE_SLOW, 32'd0));
        send(make_item(OP_MODE, 5'd1, 8'h00, 8'h00, 8'h00, MODE_PULSE_FAST, 32'd0));
        send(make_item(OP_MODE, 5'd2, 8'h00, 8'h00, 8'h00, MODE_FLASH_FAST, 32'd0));
        send(make_item(OP_MODE, 5'd31, 8'h00, 8'h00, 8'h00, MODE_FLASH_SLOW, 32'd0));
        // fraction reaches exactly 1.0, then the phase flips
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd999));
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd1001));
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd100));
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd101));
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd199));
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'hffffffff));
        // a color write alone must not touch the shown word
        send(make_item(OP_MODE, 5'd31, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd0));
        send(make_item(OP_WR_C1, 5'd31, 8'hff, 8'hff, 8'hff, MODE_OFF, 32'd0));
        send(make_item(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00, MODE_OFF, 32'd1500));
        settle();

        // Random segments, each with its own LED count and sender idling
        for (seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct = (seg < 2) ? 14 : (seg < 4) ? 69 : 0;
            case (seg)
                0: set_count(6'd1);
                1: set_count(6'($urandom_range(2, 31)));
                2: set_count(6'd0);
                3: set_count(6'd63);
                4: set_count(6'($urandom_range(2, 31)));
                default: set_count(6'd32);
            endcase
            target = (led_count == 0) ? 12 : 42;
            useful = 0;
            while (useful < target) begin
                it = random_item(led_count);
                if (it.opcode == OP_TICK || int'(it.led_index) < led_count) useful++;
                send(it);
            end
            settle();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
